/* design/wed_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wed_pkg
// Shared widths, codes, control structs and saturating arithmetic for the
// weighted edit-distance block.
// ----------------------------------------------------------------------------
package wed_pkg;

	localparam int MAX_LEN_DEF     = 64;
	localparam int SYMBOL_BITS_DEF = 16;

	localparam int MODE_W   = 2;
	localparam int SYM_IN_W = 16;
	localparam int DIST_W   = 11;
	localparam int COST_W   = 4;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [COST_W-1:0] INSERT_COST_RST     = 4'd1;
	localparam logic [COST_W-1:0] DELETE_COST_RST     = 4'd2;
	localparam logic [COST_W-1:0] SUBSTITUTE_COST_RST = 4'd3;

	typedef enum logic [MODE_W-1:0] {
		MODE_FIRST   = 2'd0,
		MODE_SECOND  = 2'd1,
		MODE_COMPUTE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REG_INSERT     = 2'd0,
		REG_DELETE     = 2'd1,
		REG_SUBSTITUTE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [COST_W-1:0] ins;
		logic [COST_W-1:0] del;
		logic [COST_W-1:0] sub;
	} costs_t;

	// controller to datapath
	typedef struct packed {
		logic load_first;
		logic load_second;
		logic start;
		logic init_step;
		logic row_step;
		logic cell_step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic len2_zero;
		logic j_last;
		logic rows_done;
	} status_t;

	function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] x,
			input logic [COST_W-1:0] c);
		logic [DIST_W:0] s;
		s = {1'b0, x} + (DIST_W+1)'(c);
		return (s > {1'b0, DIST_MAX}) ? DIST_MAX : s[DIST_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* design/wed_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wed_if
// Valid/ready channels: symbol requests in, distance results out.
// ----------------------------------------------------------------------------
interface wed_in_if;
	logic                         valid;
	logic                         ready;
	logic [wed_pkg::MODE_W-1:0]   mode;
	logic [wed_pkg::SYM_IN_W-1:0] symbol;

	modport source (output valid, mode, symbol, input ready);
	modport sink   (input valid, mode, symbol, output ready);
endinterface

interface wed_out_if;
	logic                       valid;
	logic                       ready;
	logic [wed_pkg::DIST_W-1:0] distance;
	logic                       length_overflow;

	modport source (output valid, distance, length_overflow, input ready);
	modport sink   (input valid, distance, length_overflow, output ready);
endinterface
`default_nettype wire

/* design/wed_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wed_cfg
// APB-style register file holding the three edit costs.
// ----------------------------------------------------------------------------
module wed_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wed_pkg::PADDR_W-1:0] paddr,
	input  wire logic [wed_pkg::PDATA_W-1:0] pwdata,
	output logic      [wed_pkg::PDATA_W-1:0] prdata,
	output wed_pkg::costs_t                  costs
);
	import wed_pkg::*;

	costs_t   costs_q;
	logic     wr_en;
	reg_idx_t idx;

	assign idx   = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			costs_q.ins <= INSERT_COST_RST;
			costs_q.del <= DELETE_COST_RST;
			costs_q.sub <= SUBSTITUTE_COST_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_INSERT:     costs_q.ins <= pwdata[COST_W-1:0];
				REG_DELETE:     costs_q.del <= pwdata[COST_W-1:0];
				REG_SUBSTITUTE: costs_q.sub <= pwdata[COST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_INSERT:     prdata = PDATA_W'(costs_q.ins);
			REG_DELETE:     prdata = PDATA_W'(costs_q.del);
			REG_SUBSTITUTE: prdata = PDATA_W'(costs_q.sub);
			default:        prdata = '0;
		endcase
	end

	assign costs = costs_q;
endmodule
`default_nettype wire

/* design/wed_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wed_ctrl
// Sequencer: accepts requests, walks the init row, the rows and the cells,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module wed_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [wed_pkg::MODE_W-1:0] in_mode,
	output logic                            in_ready,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	input  wire wed_pkg::status_t           status,
	output wed_pkg::cmd_t                   cmd
);
	import wed_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_INIT = 5'b00010,
		S_ROW  = 5'b00100,
		S_CELL = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_first  = accept && (in_mode == MODE_FIRST);
				cmd.load_second = accept && (in_mode == MODE_SECOND);
				if (accept && (in_mode == MODE_COMPUTE)) begin
					cmd.start = 1'b1;
					state_d   = status.len2_zero ? S_ROW : S_INIT;
				end
			end
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (status.j_last) state_d = S_ROW;
			end
			S_ROW: begin
				if (status.rows_done) begin
					state_d = S_DONE;
				end else begin
					cmd.row_step = 1'b1;
					if (!status.len2_zero) state_d = S_CELL;
				end
			end
			S_CELL: begin
				cmd.cell_step = 1'b1;
				if (status.j_last) state_d = S_ROW;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish)     out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

/* design/wed_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wed_dp
// Datapath: symbol stores, rolling cost row, cell arithmetic, counters and
// the result register.
// ----------------------------------------------------------------------------
module wed_dp #(
	parameter int MAX_LEN     = wed_pkg::MAX_LEN_DEF,
	parameter int SYMBOL_BITS = wed_pkg::SYMBOL_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [wed_pkg::SYM_IN_W-1:0] symbol,
	input  wire wed_pkg::costs_t              costs,
	input  wire wed_pkg::cmd_t                cmd,
	output wed_pkg::status_t                  status,
	output logic      [wed_pkg::DIST_W-1:0]   distance,
	output logic                              length_overflow
);
	import wed_pkg::*;

	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LEN_W = $clog2(MAX_LEN + 1);

	logic [SYMBOL_BITS-1:0] first_mem  [MAX_LEN];
	logic [SYMBOL_BITS-1:0] second_mem [MAX_LEN];
	logic [DIST_W-1:0]      row_mem    [MAX_LEN];

	logic [LEN_W-1:0]  len1_q, len2_q, i_q;
	logic [IDX_W-1:0]  j_q, j_next;
	logic              ovf_q;
	logic [DIST_W-1:0] col0_q, acc_q, left_q, diag_q;
	logic [DIST_W-1:0] col0_next, cell_cost;
	logic [DIST_W-1:0] up_rd_q;
	logic [SYMBOL_BITS-1:0] a_rd_q, b_rd_q, sym;
	logic [DIST_W-1:0] cand_ins, cand_del, cand_sub, cand_min;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_idx;
	logic [DIST_W-1:0] distance_q;
	logic              length_overflow_q;

	assign sym       = SYMBOL_BITS'(symbol);
	assign j_next    = j_q + IDX_W'(1);
	assign col0_next = sat_add(col0_q, costs.del);

	assign status.len2_zero = (len2_q == '0);
	assign status.j_last    = ((LEN_W'(j_q) + LEN_W'(1)) == len2_q);
	assign status.rows_done = (i_q == len1_q);

	// cell: match takes the diagonal, else cheapest of three moves
	always_comb begin
		cand_ins = sat_add(left_q, costs.ins);
		cand_del = sat_add(up_rd_q, costs.del);
		cand_sub = sat_add(diag_q, costs.sub);
		cand_min = (cand_ins < cand_del) ? cand_ins : cand_del;
		if (cand_sub < cand_min) cand_min = cand_sub;
		cell_cost = (a_rd_q == b_rd_q) ? diag_q : cand_min;
	end

	// first column of the next row, or the next cell of this one
	assign rd_en  = cmd.row_step || (cmd.cell_step && !status.j_last);
	assign rd_idx = cmd.row_step ? '0 : j_next;

	always_ff @(posedge clk) begin
		if (cmd.load_first && (len1_q < LEN_W'(MAX_LEN)))
			first_mem[len1_q[IDX_W-1:0]] <= sym;
		if (cmd.row_step)
			a_rd_q <= first_mem[i_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_second && (len2_q < LEN_W'(MAX_LEN)))
			second_mem[len2_q[IDX_W-1:0]] <= sym;
		if (rd_en)
			b_rd_q <= second_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.init_step)
			row_mem[j_q] <= acc_q;
		else if (cmd.cell_step)
			row_mem[j_q] <= cell_cost;
		if (rd_en)
			up_rd_q <= row_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len1_q <= '0;
			len2_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (cmd.load_first) begin
				if (len1_q < LEN_W'(MAX_LEN)) len1_q <= len1_q + LEN_W'(1);
				else                          ovf_q  <= 1'b1;
			end
			if (cmd.load_second) begin
				if (len2_q < LEN_W'(MAX_LEN)) len2_q <= len2_q + LEN_W'(1);
				else                          ovf_q  <= 1'b1;
			end
			if (cmd.finish) begin
				len1_q <= '0;
				len2_q <= '0;
				ovf_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (cmd.start) begin
				i_q <= '0;
				j_q <= '0;
			end else if (cmd.row_step) begin
				i_q <= i_q + LEN_W'(1);
				j_q <= '0;
			end else if (cmd.init_step || cmd.cell_step) begin
				j_q <= j_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			col0_q <= '0;
			acc_q  <= DIST_W'(costs.ins);
			left_q <= '0;
		end else if (cmd.init_step) begin
			acc_q  <= sat_add(acc_q, costs.ins);
			left_q <= acc_q;
		end else if (cmd.row_step) begin
			diag_q <= col0_q;
			col0_q <= col0_next;
			left_q <= col0_next;
		end else if (cmd.cell_step) begin
			diag_q <= up_rd_q;
			left_q <= cell_cost;
		end
		if (cmd.finish) begin
			distance_q        <= (len2_q == '0) ? col0_q : left_q;
			length_overflow_q <= ovf_q;
		end
	end

	assign distance        = distance_q;
	assign length_overflow = length_overflow_q;
endmodule
`default_nettype wire

/* design/weighted_edit_distance.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_edit_distance
// Weighted edit distance between two symbol sequences loaded one per request.
//
//   channel  dir  handshake              payload
//   item     in   valid/ready            mode[1:0], symbol[15:0]
//   result   out  valid/ready            distance[10:0], length_overflow
//   apb      in   psel/penable, pready=1 paddr[3:0], pwdata/prdata[31:0]
//
// A compute request walks the init row and then each row: a row step
// fetches the first-sequence symbol and advances column zero, then the cells
// follow at one cell per cycle, bounded by the single write port of the
// cost-row memory.
// Reset clears lengths, the drop flag, the state machine and result valid;
// the stores hold garbage until loaded. A result waiting on the output side
// does not block loads; a following compute holds in its last state until
// the result slot is free.
// ----------------------------------------------------------------------------
module weighted_edit_distance #(
	parameter int MAX_LEN     = wed_pkg::MAX_LEN_DEF,
	parameter int SYMBOL_BITS = wed_pkg::SYMBOL_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	wed_in_if.sink                           item,
	wed_out_if.source                        result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wed_pkg::PADDR_W-1:0] paddr,
	input  wire logic [wed_pkg::PDATA_W-1:0] pwdata,
	output logic      [wed_pkg::PDATA_W-1:0] prdata,
	output logic                             pready
);
	import wed_pkg::*;

	costs_t  costs;
	cmd_t    cmd;
	status_t status;

	// register writes complete in the access cycle, never wait
	assign pready = 1'b1;

	wed_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.costs   (costs)
	);

	// sequencer: decodes the request mode and steps through the matrix
	wed_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_mode   (item.mode),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// stores, rolling row and the cell arithmetic
	wed_dp #(
		.MAX_LEN     (MAX_LEN),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.symbol          (item.symbol),
		.costs           (costs),
		.cmd             (cmd),
		.status          (status),
		.distance        (result.distance),
		.length_overflow (result.length_overflow)
	);
endmodule
`default_nettype wire

/* design/wed_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wed_checker
// Port-level checks on the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
module wed_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic [wed_pkg::MODE_W-1:0]  in_mode,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [wed_pkg::DIST_W-1:0]  out_distance,
	input wire logic                        out_overflow
);
	import wed_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_distance) && $stable(out_overflow))
		else $error("result payload changed while stalled");

	// a compute request leaves the block not ready in the cycle after it is accepted
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_mode == MODE_COMPUTE) |=> !in_ready)
		else $error("ready right after compute request");

	// a new result only appears at the end of a compute, never from idle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");
endmodule

bind weighted_edit_distance wed_checker u_wed_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.in_mode      (item.mode),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_distance (result.distance),
	.out_overflow (result.length_overflow)
);
`default_nettype wire
